// File: design/sst_pkg.sv
// Shared types and constants for the scoped symbol table.
package sst_pkg;

  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned MaxScopesDef  = 16;
  localparam int unsigned KeyBitsDef    = 16;
  localparam int unsigned SlotBitsDef   = 16;

  // Fixed field widths on the ports
  localparam int unsigned KeyW  = 16;
  localparam int unsigned SlotW = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ENTER  = 2'd1,
    OP_ESCAPE = 2'd2,
    OP_LOOKUP = 2'd3
  } sst_op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_ESC_GLOBAL  = 3'd2,
    ST_TABLE_FULL  = 3'd3,
    ST_SCOPES_FULL = 3'd4
  } sst_status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_ESC    = 2'd1,
    S_SCAN   = 2'd2,
    S_RESULT = 2'd3
  } sst_state_e;

  typedef struct packed {
    sst_op_e          operation;
    logic [KeyW-1:0]  key;
    logic [SlotW-1:0] slot_in;
  } sst_in_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] slot_out;
    sst_status_e      status;
  } sst_out_t;

  // Per-cycle control broadcast to every cell of the entry chain
  typedef struct packed {
    logic push;    // shift towards the tail, new entry lands in cell 0
    logic rotate;  // shift towards the head, cell 0 wraps to the tail
  } sst_cell_ctl_t;

endpackage

// File: design/sst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sst_cell.sv
// One entry cell of the symbol chain: holds a key and its slot.
module sst_cell #(
  parameter int unsigned KEY_BITS  = sst_pkg::KeyBitsDef,
  parameter int unsigned SLOT_BITS = sst_pkg::SlotBitsDef
) (
  input  logic                  clk_i,
  input  sst_pkg::sst_cell_ctl_t ctl_i,
  input  logic [KEY_BITS-1:0]   prev_key_i,
  input  logic [SLOT_BITS-1:0]  prev_slot_i,
  input  logic [KEY_BITS-1:0]   next_key_i,
  input  logic [SLOT_BITS-1:0]  next_slot_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [SLOT_BITS-1:0]  slot_o
);

  logic [KEY_BITS-1:0]  key_q;
  logic [SLOT_BITS-1:0] slot_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      key_q  <= prev_key_i;
      slot_q <= prev_slot_i;
    end else if (ctl_i.rotate) begin
      key_q  <= next_key_i;
      slot_q <= next_slot_i;
    end
  end

  assign key_o  = key_q;
  assign slot_o = slot_q;

endmodule

// File: design/scoped_symbol_table.sv
// Scoped symbol table top level: request decode, entry chain and scope stack.
//
// Usage: requests arrive on in_i (in_valid_i / in_stall_o), one result per
// request leaves on out_o (out_valid_o / out_stall_i). A transfer happens on
// a rising edge with valid high and stall low.
// Entries live in a chain of MAX_ENTRIES cells, newest in cell 0. Insert
// pushes the chain by one. Lookup rotates the whole ring once, comparing
// only at cell 0, so the newest match is met first. Escape rotates the ring
// by one per discarded entry so the survivors end up from cell 0 again.
// Path from request transfer to the load of the output register:
//   insert, enter, escape of the global scope: straight to S_RESULT
//   escape: S_ESC, one rotation per discarded entry, then S_RESULT
//   lookup: S_SCAN for the full ring rotation, then S_RESULT
// No request is taken until its predecessor's result has moved into the
// output register. A stalled result keeps the next result waiting in
// S_RESULT, and no further request is taken until it leaves.
// Reset empties the table and leaves only the global scope open; stored
// keys, slots and scope starts are not cleared and need no clearing pass.
// While out_stall_i is high the output register holds its result.
module scoped_symbol_table #(
  parameter int unsigned MAX_ENTRIES = sst_pkg::MaxEntriesDef,
  parameter int unsigned MAX_SCOPES  = sst_pkg::MaxScopesDef,
  parameter int unsigned KEY_BITS    = sst_pkg::KeyBitsDef,
  parameter int unsigned SLOT_BITS   = sst_pkg::SlotBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sst_pkg::sst_in_t in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sst_pkg::sst_out_t out_o
);

  import sst_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned LvlW = $clog2(MAX_SCOPES);

  sst_state_e           state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [LvlW-1:0]      level_q, level_d;
  logic [IdxW-1:0]      scan_q, scan_d;
  logic                 found_q, found_d;
  logic [SLOT_BITS-1:0] hit_slot_q, hit_slot_d;
  logic [KEY_BITS-1:0]  look_key_q, look_key_d;
  sst_out_t             res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  sst_out_t             out_q, out_d;

  sst_cell_ctl_t        cell_ctl;
  logic [KEY_BITS-1:0]  cell_key  [MAX_ENTRIES];
  logic [SLOT_BITS-1:0] cell_slot [MAX_ENTRIES];
  logic [KEY_BITS-1:0]  in_key;
  logic [SLOT_BITS-1:0] in_slot;

  logic                 ram_we;
  logic [LvlW-1:0]      ram_waddr;
  logic [CntW-1:0]      scope_start;
  logic                 out_free;

  assign in_key   = KEY_BITS'(in_i.key);
  assign in_slot  = SLOT_BITS'(in_i.slot_in);
  assign out_free = !out_valid_q || !out_stall_i;

  // Entry chain
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [KEY_BITS-1:0]  prev_key, next_key;
    logic [SLOT_BITS-1:0] prev_slot, next_slot;

    if (g == 0) begin : g_head
      assign prev_key  = in_key;
      assign prev_slot = in_slot;
    end else begin : g_body
      assign prev_key  = cell_key[g-1];
      assign prev_slot = cell_slot[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign next_key  = cell_key[0];
      assign next_slot = cell_slot[0];
    end else begin : g_mid
      assign next_key  = cell_key[g+1];
      assign next_slot = cell_slot[g+1];
    end

    sst_cell #(
      .KEY_BITS  (KEY_BITS),
      .SLOT_BITS (SLOT_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .prev_key_i  (prev_key),
      .prev_slot_i (prev_slot),
      .next_key_i  (next_key),
      .next_slot_i (next_slot),
      .key_o       (cell_key[g]),
      .slot_o      (cell_slot[g])
    );
  end

  // Entry count at the opening of each scope
  assign ram_waddr = level_q + 1'b1;

  sst_ram #(
    .WIDTH (CntW),
    .DEPTH (MAX_SCOPES)
  ) u_scope_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (count_q),
    .raddr_i (level_q),
    .rdata_o (scope_start)
  );

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    level_d     = level_q;
    scan_d      = scan_q;
    found_d     = found_q;
    hit_slot_d  = hit_slot_q;
    look_key_d  = look_key_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    cell_ctl    = '0;
    ram_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d   = '{found: 1'b0, slot_out: '0, status: ST_OK};
          state_d = S_RESULT;
          case (in_i.operation)
            OP_INSERT: begin
              if (count_q == CntW'(MAX_ENTRIES)) begin
                res_d.status = ST_TABLE_FULL;
              end else begin
                cell_ctl.push = 1'b1;
                count_d       = count_q + 1'b1;
              end
            end
            OP_ENTER: begin
              if (level_q == LvlW'(MAX_SCOPES - 1)) begin
                res_d.status = ST_SCOPES_FULL;
              end else begin
                level_d = level_q + 1'b1;
                ram_we  = 1'b1;
              end
            end
            OP_ESCAPE: begin
              if (level_q == '0) begin
                res_d.status = ST_ESC_GLOBAL;
              end else begin
                state_d = S_ESC;
              end
            end
            OP_LOOKUP: begin
              look_key_d = in_key;
              scan_d     = '0;
              found_d    = 1'b0;
              state_d    = S_SCAN;
            end
            default: ;
          endcase
        end
      end

      S_ESC: begin
        // scope_start holds the start of the current level; drop the newest
        // entry by one rotation per cycle until the count is back there
        if (scope_start < count_q) begin
          cell_ctl.rotate = 1'b1;
          count_d         = count_q - 1'b1;
        end else begin
          level_d = level_q - 1'b1;
          state_d = S_RESULT;
        end
      end

      S_SCAN: begin
        cell_ctl.rotate = 1'b1;
        if (!found_q && (CntW'(scan_q) < count_q) && (cell_key[0] == look_key_q)) begin
          found_d    = 1'b1;
          hit_slot_d = cell_slot[0];
        end
        if (scan_q == IdxW'(MAX_ENTRIES - 1)) begin
          // ring is back in place after this rotation
          res_d.found    = found_d;
          res_d.slot_out = found_d ? SlotW'(hit_slot_d) : '0;
          res_d.status   = found_d ? ST_OK : ST_NOT_FOUND;
          state_d        = S_RESULT;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_RESULT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      level_q     <= '0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      level_q     <= level_d;
      scan_q      <= scan_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_slot_q <= hit_slot_d;
    look_key_q <= look_key_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_i.operation == OP_INSERT)
      && (count_q != CntW'(MAX_ENTRIES)))
    |=> count_q == $past(count_q) + 1'b1)
    else $error("accepted insert did not add an entry");

  a_escape_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ESC) |=> (count_q <= $past(count_q)))
    else $error("escape grew the table");

  a_escape_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ESC) && (scope_start >= count_q)) |=> (level_q == $past(level_q) - 1'b1))
    else $error("escape did not close the innermost scope");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.found) |-> (out_q.status == ST_OK))
    else $error("hit reported with an error status");

endmodule
